>>> sv/bcht_pkg.sv
// ----------------------------------------------------------------------------
// bcht_pkg
// Shared types and constants for the two-way bucketized cuckoo hash table.
// ----------------------------------------------------------------------------
package bcht_pkg;

    localparam int SLOTS_DEFAULT      = 5;
    localparam int KICKS_DEFAULT      = 16;
    localparam int BUCKET_INDEX_BITS  = 16;
    localparam int KEY_W              = 64;
    localparam int VAL_W              = 48;
    localparam int KB_W               = 48;
    localparam int SLOT_W             = KB_W + VAL_W;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_REMOVE = 2'd2,
        FN_OTHER  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_FULL    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_WT1,
        S_RD2,
        S_WT2,
        S_KRD,
        S_KWT,
        S_EMIT,
        S_LK_SCAN,
        S_OUT
    } state_t;

    // Key bits stored in a slot of the given table
    function automatic logic [KB_W-1:0] bits_of(input logic tab2, input logic [KEY_W-1:0] k);
        if (!tab2) bits_of = k[63:16];
        else       bits_of = {k[63:32], k[15:0]};
    endfunction

    function automatic logic [BUCKET_INDEX_BITS-1:0] bucket_of(input logic tab2,
                                                               input logic [KEY_W-1:0] k);
        if (!tab2) bucket_of = k[15:0];
        else       bucket_of = k[31:16];
    endfunction

    // Rebuild the full key from a slot and its bucket index
    function automatic logic [KEY_W-1:0] key_from(input logic tab2,
                                                  input logic [BUCKET_INDEX_BITS-1:0] idx,
                                                  input logic [KB_W-1:0] kb);
        if (!tab2) key_from = {kb, idx};
        else       key_from = {kb[47:16], idx, kb[15:0]};
    endfunction

endpackage

>>> sv/bcht_bucket_mem.sv
// ----------------------------------------------------------------------------
// bcht_bucket_mem
// One table: a bucket-wide synchronous RAM, one read and one write port.
// ----------------------------------------------------------------------------
module bcht_bucket_mem #(
    parameter int SLOTS = bcht_pkg::SLOTS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [bcht_pkg::BUCKET_INDEX_BITS-1:0] waddr,
    input  logic [SLOTS*bcht_pkg::SLOT_W-1:0]      wdata,
    input  logic [bcht_pkg::BUCKET_INDEX_BITS-1:0] raddr,
    output logic [SLOTS*bcht_pkg::SLOT_W-1:0]      rdata
);
    import bcht_pkg::*;

    localparam int DEPTH = 1 << BUCKET_INDEX_BITS;

    logic [SLOTS*SLOT_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/bucketized_cuckoo_hash_table_core.sv
// ----------------------------------------------------------------------------
// bucketized_cuckoo_hash_table_core
// Two-way bucketized cuckoo multimap, 64-bit keys to 48-bit values.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_func s_key s_value
//  m_      | out       | m_valid m_ready m_status m_found_value m_last
//          |           | m_pending_key m_pending_value
//
// An insert takes an empty slot in table 1, else in table 2, else it runs at
// most MAX_KICKS kick rounds; it is refused once the table is flagged full.
// A remove gives one beat; a lookup gives one beat per hit, or a miss beat.
// After reset a clearing pass zeroes every bucket of both bucket RAMs;
// no beat is taken meanwhile. Results wait in an output register while
// m_ready is low; one item is in work at a time and the next beat is taken
// only once that register has drained. A lookup holds back one hit so the
// final beat can carry m_last.
// ----------------------------------------------------------------------------
module bucketized_cuckoo_hash_table_core #(
    parameter int SLOTS     = bcht_pkg::SLOTS_DEFAULT,
    parameter int MAX_KICKS = bcht_pkg::KICKS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [bcht_pkg::KEY_W-1:0] s_key,
    input  logic [bcht_pkg::VAL_W-1:0] s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [bcht_pkg::VAL_W-1:0] m_found_value,
    output logic                       m_last,
    output logic [bcht_pkg::KEY_W-1:0] m_pending_key,
    output logic [bcht_pkg::VAL_W-1:0] m_pending_value
);
    import bcht_pkg::*;

    localparam int IW  = BUCKET_INDEX_BITS;
    localparam int BW  = SLOTS * SLOT_W;
    localparam int SW  = $clog2(SLOTS + 1);
    localparam int KW  = $clog2(MAX_KICKS + 1);

    state_t state_reg, state_next;

    logic [IW-1:0]    clr_reg, clr_next;
    func_t            func_reg, func_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             tab2_reg, tab2_next;
    logic [KW-1:0]    kick_reg, kick_next;
    logic             full_reg, full_next;
    logic [KEY_W-1:0] lk_reg, lk_next;
    logic [VAL_W-1:0] lv_reg, lv_next;
    logic             hit_reg, hit_next;
    logic [BW-1:0]    bkt_reg, bkt_next;
    logic [SW-1:0]    scan_reg, scan_next;
    logic             hold_reg, hold_next;
    logic [VAL_W-1:0] hval_reg, hval_next;

    logic             mv_reg, mv_next;
    status_t          ms_reg, ms_next;
    logic [VAL_W-1:0] mf_reg, mf_next;
    logic             ml_reg, ml_next;
    logic [KEY_W-1:0] mpk_reg, mpk_next;
    logic [VAL_W-1:0] mpv_reg, mpv_next;

    // memory ports
    logic          we1, we2;
    logic [IW-1:0] waddr, raddr;
    logic [BW-1:0] wdata, rd1, rd2, rd;

    bcht_bucket_mem #(.SLOTS(SLOTS)) u_tab1 (
        .aclk(aclk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
    );
    bcht_bucket_mem #(.SLOTS(SLOTS)) u_tab2 (
        .aclk(aclk), .we(we2), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd2)
    );

    assign rd = tab2_reg ? rd2 : rd1;

    // per-slot views of the read bucket
    logic [KB_W-1:0]  sk [SLOTS];
    logic [VAL_W-1:0] sv [SLOTS];
    logic [KB_W-1:0]  bk [SLOTS];
    logic [VAL_W-1:0] bv [SLOTS];
    logic [KB_W-1:0]  want;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            sv[i] = rd[i*SLOT_W +: VAL_W];
            sk[i] = rd[i*SLOT_W + VAL_W +: KB_W];
            bv[i] = bkt_reg[i*SLOT_W +: VAL_W];
            bk[i] = bkt_reg[i*SLOT_W + VAL_W +: KB_W];
        end
        want = bits_of(tab2_reg, key_reg);
    end

    // first empty slot
    logic          emp_found;
    logic [SW-1:0] emp_idx;
    always_comb begin
        emp_found = 1'b0;
        emp_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (sk[i] == '0 && sv[i] == '0) begin
                emp_found = 1'b1;
                emp_idx   = SW'(i);
            end
        end
    end

    // remove scan over the bucket, applied sequentially per slot
    logic [BW-1:0] rm_bkt;
    logic          rm_hit;
    always_comb begin
        logic [KB_W-1:0]  k [SLOTS];
        logic [VAL_W-1:0] v [SLOTS];
        for (int i = 0; i < SLOTS; i++) begin
            k[i] = sk[i];
            v[i] = sv[i];
        end
        rm_hit = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (k[i] == want && v[i] == val_reg) begin
                k[i] = k[SLOTS-1];
                v[i] = v[SLOTS-1];
                k[SLOTS-1] = '0;
                v[SLOTS-1] = '0;
                rm_hit = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            rm_bkt[i*SLOT_W +: SLOT_W] = {k[i], v[i]};
        end
    end

    // kick: shift up, new entry in slot zero
    logic [BW-1:0] kick_bkt;
    logic [KB_W-1:0]  ev_k;
    logic [VAL_W-1:0] ev_v;
    always_comb begin
        kick_bkt = {rd[BW-SLOT_W-1:0], want, val_reg};
        if (SLOTS == 1) kick_bkt = {want, val_reg};
        ev_k = sk[SLOTS-1];
        ev_v = sv[SLOTS-1];
    end

    // next lookup hit at or above scan position
    logic          lk_found;
    logic [SW-1:0] lk_idx;
    always_comb begin
        lk_found = 1'b0;
        lk_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (SW'(i) >= scan_reg && bk[i] == want && bv[i] != '0) begin
                lk_found = 1'b1;
                lk_idx   = SW'(i);
            end
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            full_reg  <= 1'b0;
            lk_reg    <= '0;
            lv_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            full_reg  <= full_next;
            lk_reg    <= lk_next;
            lv_reg    <= lv_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        tab2_reg <= tab2_next;
        kick_reg <= kick_next;
        hit_reg  <= hit_next;
        bkt_reg  <= bkt_next;
        scan_reg <= scan_next;
        hold_reg <= hold_next;
        hval_reg <= hval_next;
        ms_reg   <= ms_next;
        mf_reg   <= mf_next;
        ml_reg   <= ml_next;
        mpk_reg  <= mpk_next;
        mpv_reg  <= mpv_next;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        func_next  = func_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        tab2_next  = tab2_reg;
        kick_next  = kick_reg;
        full_next  = full_reg;
        lk_next    = lk_reg;
        lv_next    = lv_reg;
        hit_next   = hit_reg;
        bkt_next   = bkt_reg;
        scan_next  = scan_reg;
        hold_next  = hold_reg;
        hval_next  = hval_reg;
        mv_next    = mv_reg;
        ms_next    = ms_reg;
        mf_next    = mf_reg;
        ml_next    = ml_reg;
        mpk_next   = mpk_reg;
        mpv_next   = mpv_reg;
        we1        = 1'b0;
        we2        = 1'b0;
        waddr      = bucket_of(tab2_reg, key_reg);
        wdata      = '0;
        raddr      = bucket_of(tab2_reg, key_reg);
        s_ready    = 1'b0;

        if (mv_reg && m_ready) mv_next = 1'b0;

        case (state_reg)
            // zero both RAMs, one bucket a cycle
            S_CLEAR: begin
                we1      = 1'b1;
                we2      = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = !mv_reg;
                if (s_valid && !mv_reg) begin
                    func_next = func_t'(s_func);
                    key_next  = s_key;
                    val_next  = s_value;
                    tab2_next = 1'b0;
                    kick_next = '0;
                    hit_next  = 1'b0;
                    hold_next = 1'b0;
                    state_next = S_RD1;
                end
            end
            S_RD1: begin
                if (func_reg == FN_INSERT && full_reg) begin
                    ms_next = ST_REFUSED; mpk_next = lk_reg; mpv_next = lv_reg;
                    state_next = S_EMIT;
                end else if (func_reg == FN_OTHER) begin
                    ms_next = ST_MISS; mpk_next = '0; mpv_next = '0;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_WT1;
                end
            end
            S_WT1, S_WT2: begin
                bkt_next = rd;
                case (func_reg)
                    FN_INSERT: begin
                        if (emp_found) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                wdata[i*SLOT_W +: SLOT_W] = (SW'(i) == emp_idx) ?
                                    {want, val_reg} : {sk[i], sv[i]};
                            end
                            we1 = !tab2_reg; we2 = tab2_reg;
                            ms_next = ST_OK; mpk_next = '0; mpv_next = '0;
                            state_next = S_EMIT;
                        end else if (!tab2_reg) begin
                            tab2_next = 1'b1; state_next = S_RD2;
                        end else begin
                            tab2_next = 1'b0; state_next = S_KRD;
                        end
                    end
                    FN_REMOVE: begin
                        wdata = rm_bkt;
                        we1 = !tab2_reg; we2 = tab2_reg;
                        hit_next = hit_reg | rm_hit;
                        if (!tab2_reg) begin
                            tab2_next = 1'b1; state_next = S_RD2;
                        end else begin
                            ms_next = (hit_reg | rm_hit) ? ST_OK : ST_MISS;
                            mpk_next = '0; mpv_next = '0;
                            state_next = S_EMIT;
                        end
                    end
                    default: begin
                        scan_next = '0;
                        state_next = S_LK_SCAN;
                    end
                endcase
            end
            S_RD2: state_next = S_WT2;
            S_KRD: state_next = S_KWT;
            // one kick round
            S_KWT: begin
                wdata = kick_bkt;
                we1 = !tab2_reg; we2 = tab2_reg;
                if (ev_k == '0 && ev_v == '0) begin
                    ms_next = ST_OK; mpk_next = '0; mpv_next = '0;
                    state_next = S_EMIT;
                end else begin
                    key_next  = key_from(tab2_reg, bucket_of(tab2_reg, key_reg), ev_k);
                    val_next  = ev_v;
                    tab2_next = !tab2_reg;
                    kick_next = kick_reg + 1'b1;
                    if (kick_reg == KW'(MAX_KICKS - 1)) begin
                        full_next = 1'b1;
                        lk_next   = key_from(tab2_reg, bucket_of(tab2_reg, key_reg), ev_k);
                        lv_next   = ev_v;
                        ms_next   = ST_FULL;
                        mpk_next  = key_from(tab2_reg, bucket_of(tab2_reg, key_reg), ev_k);
                        mpv_next  = ev_v;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_KRD;
                    end
                end
            end
            // single-beat result
            S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1; mf_next = '0; ml_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // lookup: hold one hit, send the held one when the next is found
            S_LK_SCAN: begin
                if (lk_found) begin
                    if (!hold_reg) begin
                        hold_next = 1'b1;
                        hval_next = bv[lk_idx];
                        scan_next = lk_idx + 1'b1;
                    end else if (!mv_reg || m_ready) begin
                        mv_next = 1'b1; ms_next = ST_OK;
                        mf_next = hval_reg; ml_next = 1'b0;
                        mpk_next = '0; mpv_next = '0;
                        hval_next = bv[lk_idx];
                        scan_next = lk_idx + 1'b1;
                    end
                end else if (!tab2_reg) begin
                    tab2_next = 1'b1; state_next = S_RD2;
                end else begin
                    state_next = S_OUT;
                end
            end
            // close the lookup: held hit as last beat, or a miss
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next  = 1'b1;
                    ms_next  = hold_reg ? ST_OK : ST_MISS;
                    mf_next  = hold_reg ? hval_reg : '0;
                    ml_next  = 1'b1; mpk_next = '0; mpv_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid         = mv_reg;
    assign m_status        = ms_reg;
    assign m_found_value   = mf_reg;
    assign m_last          = ml_reg;
    assign m_pending_key   = mpk_reg;
    assign m_pending_value = mpv_reg;

endmodule
